// ===== sv/u8d_pkg.sv =====
// Shared types, constants and the per-byte decode function for the UTF-8 stream decoder.
// Used by the channel interfaces and all decoder modules; depends on nothing.
package u8d_pkg;

    localparam int DataW     = 8;
    localparam int CpW       = 21;
    localparam int MaxRes    = 3;
    localparam int CntW      = 2;
    localparam int ApbDataW  = 32;
    localparam int ApbAddrW  = 3;

    // Register index, taken from the word address paddr[2].
    localparam logic RegUtf8Mode = 1'b0;

    // Byte codes.
    localparam logic [7:0] BomByte0  = 8'hEF;
    localparam logic [7:0] BomByte1  = 8'hBB;
    localparam logic [7:0] BomByte2  = 8'hBF;
    localparam logic [7:0] ContMask  = 8'hC0;
    localparam logic [7:0] ContTag   = 8'h80;
    localparam logic [7:0] Lead2Mask = 8'hE0;
    localparam logic [7:0] Lead2Tag  = 8'hC0;
    localparam logic [7:0] Lead3Mask = 8'hF0;
    localparam logic [7:0] Lead3Tag  = 8'hE0;
    localparam logic [7:0] Lead4Mask = 8'hF8;
    localparam logic [7:0] Lead4Tag  = 8'hF0;
    localparam logic [7:0] BadLeadC0 = 8'hC0;
    localparam logic [7:0] BadLeadC1 = 8'hC1;
    localparam logic [7:0] LeadLimit = 8'hF5;

    typedef struct packed {
        logic [CpW-1:0] code_point;
        logic           end_marker;
    } t_result;

    typedef struct packed {
        logic [CntW-1:0]            cnt;
        t_result [MaxRes-1:0]       res;
    } t_bundle;

    // Request from the core to the result buffer.
    typedef struct packed {
        logic    load;
        t_bundle bnd;
    } t_push;

    typedef struct packed {
        logic [CntW-1:0] pend;
        logic [CpW-1:0]  part;
        logic            emit;
        logic [CpW-1:0]  cp;
        logic            marker;
    } t_dec;

    // Decodes one byte against the sequence state.
    function automatic t_dec dec_byte(input logic [CntW-1:0] pend,
                                      input logic [CpW-1:0]  part,
                                      input logic [DataW-1:0] b,
                                      input logic utf8);
        t_dec d;
        d.pend   = pend;
        d.part   = part;
        d.emit   = 1'b0;
        d.cp     = '0;
        d.marker = 1'b0;
        if (!utf8) begin
            d.pend = '0;
            d.part = '0;
            d.emit = 1'b1;
            d.cp   = {{(CpW-DataW){1'b0}}, b};
        end else if (pend != '0) begin
            if ((b & ContMask) == ContTag) begin
                case (pend)
                    2'd1:    d.part = part | {15'b0, b[5:0]};
                    2'd2:    d.part = part | {9'b0, b[5:0], 6'b0};
                    default: d.part = part | {3'b0, b[5:0], 12'b0};
                endcase
                d.pend = pend - 2'd1;
                if (d.pend == '0) begin
                    d.emit = 1'b1;
                    d.cp   = d.part;
                end
            end else begin
                d.pend   = '0;
                d.part   = '0;
                d.emit   = 1'b1;
                d.marker = 1'b1;
            end
        end else if (!b[7]) begin
            d.emit = 1'b1;
            d.cp   = {{(CpW-DataW){1'b0}}, b};
        end else if ((b & Lead2Mask) == Lead2Tag) begin
            if (b == BadLeadC0 || b == BadLeadC1) begin
                d.emit   = 1'b1;
                d.marker = 1'b1;
            end else begin
                d.part = {10'b0, b[4:0], 6'b0};
                d.pend = 2'd1;
            end
        end else if ((b & Lead3Mask) == Lead3Tag) begin
            d.part = {5'b0, b[3:0], 12'b0};
            d.pend = 2'd2;
        end else if ((b & Lead4Mask) == Lead4Tag && b < LeadLimit) begin
            // Leads F0..F4 carry at most three value bits.
            d.part = {b[2:0], 18'b0};
            d.pend = 2'd3;
        end else begin
            d.emit   = 1'b1;
            d.marker = 1'b1;
        end
        return d;
    endfunction

    // Appends a result to a bundle when one is produced.
    function automatic t_bundle add_res(input t_bundle bi, input logic emit,
                                        input logic [CpW-1:0] cp, input logic marker);
        t_bundle bo;
        bo = bi;
        if (emit && bi.cnt < CntW'(MaxRes)) begin
            bo.res[bi.cnt].code_point = marker ? '0 : cp;
            bo.res[bi.cnt].end_marker = marker;
            bo.cnt = bi.cnt + 2'd1;
        end
        return bo;
    endfunction

endpackage

// ===== sv/u8d_in_if.sv =====
// Byte input channel of the UTF-8 stream decoder: valid/ready with byte and end flag.
// Depends on u8d_pkg.
interface u8d_in_if;
    logic                         valid;
    logic                         ready;
    logic [u8d_pkg::DataW-1:0]    data_byte;
    logic                         end_of_stream;

    modport source (output valid, output data_byte, output end_of_stream, input ready);
    modport sink   (input valid, input data_byte, input end_of_stream, output ready);
endinterface

// ===== sv/u8d_out_if.sv =====
// Result channel of the UTF-8 stream decoder: valid/ready with code point and flags.
// Depends on u8d_pkg.
interface u8d_out_if;
    logic                       valid;
    logic                       ready;
    logic [u8d_pkg::CpW-1:0]    code_point;
    logic                       end_marker;
    logic                       last_of_run;

    modport source (output valid, output code_point, output end_marker,
                    output last_of_run, input ready);
    modport sink   (input valid, input code_point, input end_marker,
                    input last_of_run, output ready);
endinterface

// ===== sv/u8d_cfg.sv =====
// APB-style configuration register block holding the utf8_mode bit.
// Depends on u8d_pkg.
module u8d_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [u8d_pkg::ApbAddrW-1:0]   paddr,
    input  logic [u8d_pkg::ApbDataW-1:0]   pwdata,
    output logic [u8d_pkg::ApbDataW-1:0]   prdata,
    output logic                           pready,
    output logic                           o_utf8_mode
);
    logic r_utf8_mode;
    logic n_utf8_mode;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb begin
        n_utf8_mode = r_utf8_mode;
        if (wr_en && paddr[2] == u8d_pkg::RegUtf8Mode) begin
            n_utf8_mode = pwdata[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_utf8_mode <= 1'b0;
        end else begin
            r_utf8_mode <= n_utf8_mode;
        end
    end

    assign prdata      = (paddr[2] == u8d_pkg::RegUtf8Mode)
                         ? {{(u8d_pkg::ApbDataW-1){1'b0}}, r_utf8_mode} : '0;
    assign o_utf8_mode = r_utf8_mode;
endmodule

// ===== sv/u8d_core.sv =====
// Input register, decode state and the single-pass decode that turns one request into
// up to three results. Depends on u8d_pkg and u8d_in_if.
module u8d_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_utf8_mode,
    input  logic            i_buf_free,
    u8d_in_if.sink          i_in,
    output u8d_pkg::t_push  o_push
);
    typedef enum logic [1:0] {
        PH_NONE,
        PH_EF,
        PH_EFBB,
        PH_DONE
    } t_phase;

    logic                          r_vld;
    logic [u8d_pkg::DataW-1:0]     r_byte;
    logic                          r_eos;
    t_phase                        r_phase;
    logic                          r_bom;
    logic [u8d_pkg::CntW-1:0]      r_pend;
    logic [u8d_pkg::CpW-1:0]       r_part;

    t_phase                        n_phase;
    logic                          n_bom;
    logic [u8d_pkg::CntW-1:0]      n_pend;
    logic [u8d_pkg::CpW-1:0]       n_part;

    logic                          utf8;
    logic                          bom_step;
    logic                          flush;
    logic                          consume;
    logic                          take;
    u8d_pkg::t_bundle              bnd;
    u8d_pkg::t_dec                 d0;
    u8d_pkg::t_dec                 d1;
    u8d_pkg::t_dec                 d2;

    assign utf8 = i_utf8_mode | r_bom;

    assign bom_step = !r_eos &&
                      ((r_phase == PH_NONE && r_byte == u8d_pkg::BomByte0) ||
                       (r_phase == PH_EF   && r_byte == u8d_pkg::BomByte1) ||
                       (r_phase == PH_EFBB && r_byte == u8d_pkg::BomByte2));
    assign flush = !bom_step;

    // Held BOM bytes are replayed first, then the new byte or, at end of stream, the tail.
    always_comb begin
        bnd    = '0;
        n_pend = r_pend;
        n_part = r_part;
        d0     = '0;
        d1     = '0;
        d2     = '0;
        if (flush && (r_phase == PH_EF || r_phase == PH_EFBB)) begin
            d0     = u8d_pkg::dec_byte(n_pend, n_part, u8d_pkg::BomByte0, utf8);
            bnd    = u8d_pkg::add_res(bnd, d0.emit, d0.cp, d0.marker);
            n_pend = d0.pend;
            n_part = d0.part;
        end
        if (flush && r_phase == PH_EFBB) begin
            d1     = u8d_pkg::dec_byte(n_pend, n_part, u8d_pkg::BomByte1, utf8);
            bnd    = u8d_pkg::add_res(bnd, d1.emit, d1.cp, d1.marker);
            n_pend = d1.pend;
            n_part = d1.part;
        end
        if (flush && !r_eos) begin
            d2     = u8d_pkg::dec_byte(n_pend, n_part, r_byte, utf8);
            bnd    = u8d_pkg::add_res(bnd, d2.emit, d2.cp, d2.marker);
            n_pend = d2.pend;
            n_part = d2.part;
        end
        if (r_eos) begin
            if (n_pend != '0) begin
                n_pend = '0;
                n_part = '0;
                bnd    = u8d_pkg::add_res(bnd, 1'b1, '0, 1'b1);
            end
            bnd = u8d_pkg::add_res(bnd, 1'b1, '0, 1'b1);
        end
    end

    always_comb begin
        n_phase = PH_DONE;
        n_bom   = r_bom;
        if (bom_step) begin
            unique case (r_phase)
                PH_NONE: n_phase = PH_EF;
                PH_EF:   n_phase = PH_EFBB;
                default: begin
                    n_phase = PH_DONE;
                    n_bom   = 1'b1;
                end
            endcase
        end
    end

    // An item leaves the input register when it makes no result or the buffer is free.
    assign consume    = r_vld && (bnd.cnt == '0 || i_buf_free);
    assign i_in.ready = !r_vld || consume;
    assign take       = i_in.valid && i_in.ready;

    assign o_push.load = consume && bnd.cnt != '0;
    assign o_push.bnd  = bnd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= 1'b0;
            r_phase <= PH_NONE;
            r_bom   <= 1'b0;
            r_pend  <= '0;
            r_part  <= '0;
        end else begin
            if (take) begin
                r_vld <= 1'b1;
            end else if (consume) begin
                r_vld <= 1'b0;
            end
            if (consume) begin
                r_phase <= n_phase;
                r_bom   <= n_bom;
                r_pend  <= n_pend;
                r_part  <= n_part;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_byte <= i_in.data_byte;
            r_eos  <= i_in.end_of_stream;
        end
    end
endmodule

// ===== sv/u8d_out_buf.sv =====
// Result register stage: holds one request's results and hands them out one per cycle
// while o_out.ready is high. Depends on u8d_pkg and u8d_out_if.
module u8d_out_buf (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  u8d_pkg::t_push  i_push,
    output logic            o_buf_free,
    u8d_out_if.source       o_out
);
    logic [u8d_pkg::CntW-1:0]             r_cnt;
    logic [u8d_pkg::CntW-1:0]             n_cnt;
    u8d_pkg::t_result [u8d_pkg::MaxRes-1:0] r_res;
    u8d_pkg::t_result [u8d_pkg::MaxRes-1:0] n_res;
    logic                                 fire;

    assign o_out.valid       = r_cnt != '0;
    assign o_out.code_point  = r_res[0].code_point;
    assign o_out.end_marker  = r_res[0].end_marker;
    assign o_out.last_of_run = r_cnt == 2'd1;

    assign fire       = o_out.valid && o_out.ready;
    assign o_buf_free = (r_cnt == '0) || (fire && r_cnt == 2'd1);

    always_comb begin
        n_cnt = r_cnt;
        n_res = r_res;
        if (i_push.load) begin
            n_cnt = i_push.bnd.cnt;
            n_res = i_push.bnd.res;
        end else if (fire) begin
            n_cnt    = r_cnt - 2'd1;
            n_res[0] = r_res[1];
            n_res[1] = r_res[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end
endmodule

// ===== sv/utf8_stream_decoder.sv =====
// UTF-8 stream decoder top level: configuration register, decode core, result buffer.
// Depends on u8d_pkg, u8d_in_if, u8d_out_if, u8d_cfg, u8d_core and u8d_out_buf.
//
// Usage: bytes arrive on i_in (valid/ready, data_byte, end_of_stream) and code points
// leave on o_out (valid/ready, code_point, end_marker, last_of_run). An end_of_stream
// request flushes held bytes, reports a cut-off sequence, then gives the end marker.
// The APB port holds utf8_mode at address 0; write it only while the block is idle.
// Timing: a request is taken into the input register, decoded out of it, and its
// results are loaded into the result register, from which they show on o_out.
// Throughput: one request per cycle while each makes at most one result and o_out
// is ready. A request with several results holds the result register until all have
// gone, one a cycle while o_out.ready is high; requests making no result (BOM bytes,
// inner continuation bytes) still flow one per cycle. The result and input registers
// are separate, so a new request is taken while a finished result waits.
// Reset: i_rst_n low at a clock edge clears the mode, the BOM detector, any partial
// sequence and both registers; no result is valid afterwards.
// Stall: with o_out.ready low the result register holds its result, the input
// register takes one more request, and if it makes results, i_in.ready drops.
module utf8_stream_decoder (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    u8d_in_if.sink                         i_in,
    u8d_out_if.source                      o_out,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [u8d_pkg::ApbAddrW-1:0]   paddr,
    input  logic [u8d_pkg::ApbDataW-1:0]   pwdata,
    output logic [u8d_pkg::ApbDataW-1:0]   prdata,
    output logic                           pready
);
    logic           utf8_mode;
    logic           buf_free;
    u8d_pkg::t_push push;

    u8d_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_utf8_mode (utf8_mode)
    );

    u8d_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_utf8_mode (utf8_mode),
        .i_buf_free  (buf_free),
        .i_in        (i_in),
        .o_push      (push)
    );

    u8d_out_buf u_out_buf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .o_buf_free (buf_free),
        .o_out      (o_out)
    );
endmodule

// ===== sv/u8d_checker.sv =====
// Port-level checks for the UTF-8 stream decoder, attached to the top level by bind.
// Depends on u8d_pkg and utf8_stream_decoder.
module u8d_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_out_valid,
    input  logic                       i_out_ready,
    input  logic [u8d_pkg::CpW-1:0]    i_code_point,
    input  logic                       i_end_marker,
    input  logic                       i_last_of_run
);
    // A marker result never carries a value.
    a_marker_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_end_marker |-> i_code_point == '0)
        else $error("marker result with nonzero code point");

    // A request's results come back to back: a taken result that is not the last
    // leaves another one ready in the next cycle.
    a_run_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && !i_last_of_run |=> i_out_valid)
        else $error("result run broken before its last result");

    // Decoded values stay within what four-byte leads up to F4 can form.
    a_cp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_end_marker |-> i_code_point <= 21'h13FFFF)
        else $error("code point out of range");

    // Reset empties the result register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // A stalled result holds.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_code_point)
            && $stable(i_end_marker) && $stable(i_last_of_run))
        else $error("stalled result changed");
endmodule

bind utf8_stream_decoder u8d_checker u_u8d_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_code_point  (o_out.code_point),
    .i_end_marker  (o_out.end_marker),
    .i_last_of_run (o_out.last_of_run)
);

// ===== bench/tb_utf8_stream_decoder.sv =====
// Self-checking testbench for utf8_stream_decoder: directed openings, raw and UTF-8
// sequences, a mode switch, then random byte streams, checked against an in-bench
// decoder. Depends on u8d_pkg, u8d_in_if, u8d_out_if and the decoder RTL.
`timescale 1ns / 100ps

module tb_utf8_stream_decoder;

    typedef enum logic [1:0] {
        PhNone  = 2'd0,
        PhEf    = 2'd1,
        PhEfBb  = 2'd2,
        PhDone  = 2'd3
    } t_bom_phase;

    typedef logic [u8d_pkg::CpW-1:0] t_cp;

    typedef struct packed {
        t_cp            code_point;
        logic           end_marker;
        logic           last_of_run;
    } t_point;

    logic i_clk;
    logic i_rst_n;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [u8d_pkg::ApbAddrW-1:0] paddr;
    logic [u8d_pkg::ApbDataW-1:0] pwdata;
    logic [u8d_pkg::ApbDataW-1:0] prdata;
    logic                         pready;

    u8d_in_if  in_ch ();
    u8d_out_if out_ch ();

    utf8_stream_decoder i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Decoder state as the bench sees it.
    logic           cfg_utf8;
    t_bom_phase     bom_phase;
    logic           bom_seen;
    logic [1:0]     cont_left;
    t_cp            acc_value;

    t_point run_buf [u8d_pkg::MaxRes];
    int     run_count;
    t_point pending_points [$];

    int  fail_count;
    int  items_sent;
    bit  src_quiet;
    bit  sink_quiet;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #(5_000_000);
        $display("Verification failed");
        $finish;
    end

    // ---------------------------------------------------------------- prediction

    function automatic void add_point(input t_cp cp, input logic marker);
        if (run_count < u8d_pkg::MaxRes) begin
            run_buf[run_count].code_point  = marker ? '0 : cp;
            run_buf[run_count].end_marker  = marker;
            run_buf[run_count].last_of_run = 1'b0;
            run_count++;
        end
    endfunction

    function automatic void utf8_take_byte(input logic [7:0] b);
        int sh;
        if (!(cfg_utf8 || bom_seen)) begin
            cont_left = '0;
            acc_value = '0;
            add_point(t_cp'(b), 1'b0);
        end else if (cont_left != 2'd0) begin
            if ((b & u8d_pkg::ContMask) == u8d_pkg::ContTag) begin
                sh = 6 * (int'(cont_left) - 1);
                acc_value = acc_value | (t_cp'(b[5:0]) << sh);
                cont_left = cont_left - 2'd1;
                if (cont_left == 2'd0)
                    add_point(acc_value, 1'b0);
            end else begin
                cont_left = '0;
                acc_value = '0;
                add_point('0, 1'b1);
            end
        end else if (!b[7]) begin
            add_point(t_cp'(b), 1'b0);
        end else if ((b & u8d_pkg::Lead2Mask) == u8d_pkg::Lead2Tag) begin
            if (b == u8d_pkg::BadLeadC0 || b == u8d_pkg::BadLeadC1) begin
                add_point('0, 1'b1);
            end else begin
                acc_value = t_cp'(b[4:0]) << 6;
                cont_left = 2'd1;
            end
        end else if ((b & u8d_pkg::Lead3Mask) == u8d_pkg::Lead3Tag) begin
            acc_value = t_cp'(b[3:0]) << 12;
            cont_left = 2'd2;
        end else if ((b & u8d_pkg::Lead4Mask) == u8d_pkg::Lead4Tag
                     && b < u8d_pkg::LeadLimit) begin
            acc_value = t_cp'(b[3:0]) << 18;
            cont_left = 2'd3;
        end else begin
            add_point('0, 1'b1);
        end
    endfunction

    // Bytes held while looking for a byte order mark are decoded as plain stream.
    function automatic void release_held_bom();
        if (bom_phase == PhEf) begin
            utf8_take_byte(u8d_pkg::BomByte0);
        end else if (bom_phase == PhEfBb) begin
            utf8_take_byte(u8d_pkg::BomByte0);
            utf8_take_byte(u8d_pkg::BomByte1);
        end
        bom_phase = PhDone;
    endfunction

    function automatic void account_request(input logic [7:0] b, input logic eos);
        t_point p;
        run_count = 0;
        if (eos) begin
            release_held_bom();
            if (cont_left != 2'd0) begin
                cont_left = '0;
                acc_value = '0;
                add_point('0, 1'b1);
            end
            add_point('0, 1'b1);
        end else if (bom_phase == PhNone && b == u8d_pkg::BomByte0) begin
            bom_phase = PhEf;
        end else if (bom_phase == PhEf && b == u8d_pkg::BomByte1) begin
            bom_phase = PhEfBb;
        end else if (bom_phase == PhEfBb && b == u8d_pkg::BomByte2) begin
            bom_phase = PhDone;
            bom_seen  = 1'b1;
        end else begin
            release_held_bom();
            utf8_take_byte(b);
        end
        for (int i = 0; i < run_count; i++) begin
            p = run_buf[i];
            p.last_of_run = (i == run_count - 1);
            pending_points.push_back(p);
        end
    endfunction

    // ---------------------------------------------------------------- drivers

    function automatic int draw_wait(input bit quiet);
        return quiet ? 0 : $urandom_range(0, 16);
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_request(input logic [7:0] b, input logic eos);
        int gap;
        if (items_sent % 32 == 0)
            src_quiet = ($urandom_range(0, 3) == 0);
        gap = draw_wait(src_quiet);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.data_byte     <= b;
        in_ch.end_of_stream <= eos;
        @(posedge i_clk);
        while (!in_ch.ready)
            @(posedge i_clk);
        account_request(b, eos);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_end();
        send_request(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic apb_write_mode(input logic value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {u8d_pkg::RegUtf8Mode, 2'b00};
        pwdata  <= {{(u8d_pkg::ApbDataW-1){1'b0}}, value};
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        cfg_utf8 = value;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Lets every expected result drain, then waits on for requests that produce
    // nothing but may still sit in the input register.
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (pending_points.size() != 0)
            @(negedge i_clk);
        repeat (6) @(negedge i_clk);
    endtask

    function automatic logic [7:0] cont_byte();
        return u8d_pkg::ContTag | 8'($urandom_range(0, 63));
    endfunction

    task automatic send_char(input int len);
        logic [7:0] lead;
        case (len)
            1:       lead = 8'($urandom_range(8'h00, 8'h7F));
            2:       lead = 8'($urandom_range(8'hC2, 8'hDF));
            3:       lead = 8'($urandom_range(8'hE0, 8'hEF));
            default: lead = 8'($urandom_range(8'hF0, 8'hF4));
        endcase
        send_request(lead, 1'b0);
        repeat (len - 1) send_request(cont_byte(), 1'b0);
    endtask

    // ---------------------------------------------------------------- sink side

    initial begin
        int stall;
        int taken;
        out_ch.ready <= 1'b0;
        taken = 0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if (taken % 24 == 0)
                sink_quiet = ($urandom_range(0, 3) == 0);
            stall = draw_wait(sink_quiet);
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!out_ch.valid)
                @(posedge i_clk);
            taken++;
            @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin : check_points
        t_point want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_points.size() == 0) begin
                if (fail_count < 10)
                    $display("Unexpected result: cp=%h marker=%b last=%b",
                             out_ch.code_point, out_ch.end_marker, out_ch.last_of_run);
                fail_count++;
            end else begin
                want = pending_points.pop_front();
                if (out_ch.code_point !== want.code_point
                        || out_ch.end_marker !== want.end_marker
                        || out_ch.last_of_run !== want.last_of_run) begin
                    if (fail_count < 10)
                        $display("Mismatch: expected cp=%h marker=%b last=%b, ",
                                 want.code_point, want.end_marker, want.last_of_run,
                                 "got cp=%h marker=%b last=%b",
                                 out_ch.code_point, out_ch.end_marker,
                                 out_ch.last_of_run);
                    fail_count++;
                end
            end
        end
    end

    // ---------------------------------------------------------------- tests

    // A byte order mark is only looked for right after reset, so each run
    // takes one of the possible openings.
    task automatic test_stream_opening();
        apb_write_mode(1'($urandom_range(0, 1)));
        case ($urandom_range(0, 4))
            0: begin
                send_request(u8d_pkg::BomByte0, 1'b0);
                send_request(u8d_pkg::BomByte1, 1'b0);
                send_request(u8d_pkg::BomByte2, 1'b0);
                send_request(8'h41, 1'b0);
            end
            1: begin
                send_request(u8d_pkg::BomByte0, 1'b0);
                send_request(u8d_pkg::BomByte1, 1'b0);
                send_request(8'h41, 1'b0);
            end
            2: begin
                send_request(u8d_pkg::BomByte0, 1'b0);
                send_request(8'hC3, 1'b0);
            end
            3: begin
                send_request(u8d_pkg::BomByte0, 1'b0);
                send_request(u8d_pkg::BomByte1, 1'b0);
                send_end();
            end
            default: send_request(8'h41, 1'b0);
        endcase
        wait_idle();
    endtask

    task automatic test_raw_bytes();
        apb_write_mode(1'b0);
        send_request(8'h00, 1'b0);
        send_request(8'hFF, 1'b0);
        send_request(u8d_pkg::ContTag, 1'b0);
        send_request(u8d_pkg::BadLeadC0, 1'b0);
        send_end();
        wait_idle();
    endtask

    task automatic test_utf8_sequences();
        apb_write_mode(1'b1);
        send_request(8'h41, 1'b0);
        send_request(8'hC2, 1'b0);
        send_request(8'hA9, 1'b0);
        send_request(8'hE2, 1'b0);
        send_request(8'h82, 1'b0);
        send_request(8'hAC, 1'b0);
        // Largest value the four-byte form can carry, above the Unicode range.
        send_request(8'hF4, 1'b0);
        send_request(8'hBF, 1'b0);
        send_request(8'hBF, 1'b0);
        send_request(8'hBF, 1'b0);
        send_request(u8d_pkg::BadLeadC0, 1'b0);
        send_request(u8d_pkg::BadLeadC1, 1'b0);
        send_request(u8d_pkg::LeadLimit, 1'b0);
        send_request(u8d_pkg::ContTag, 1'b0);
        // A bad continuation is swallowed with its sequence, leaving an end marker.
        send_request(8'hE2, 1'b0);
        send_request(8'h41, 1'b0);
        // Cut-off sequence at the end of the stream.
        send_request(8'hF0, 1'b0);
        send_request(8'h9F, 1'b0);
        send_end();
        wait_idle();
    endtask

    task automatic test_mode_switch_mid_sequence();
        apb_write_mode(1'b1);
        send_request(8'hE2, 1'b0);
        send_request(8'h82, 1'b0);
        wait_idle();
        apb_write_mode(1'b0);
        send_request(8'h41, 1'b0);
        wait_idle();
        apb_write_mode(1'b1);
        send_request(8'hAC, 1'b0);
        wait_idle();
    endtask

    task automatic test_random_stream(input logic mode, input int count);
        int stop_at;
        int r;
        apb_write_mode(mode);
        stop_at = items_sent + count;
        while (items_sent < stop_at) begin
            r = $urandom_range(0, 99);
            if (!(cfg_utf8 || bom_seen)) begin
                if (r < 95)
                    send_request(8'($urandom_range(0, 255)), 1'b0);
                else
                    send_end();
            end else if (r < 70) begin
                send_char($urandom_range(1, 4));
            end else if (r < 78) begin
                send_request(8'($urandom_range(0, 255)), 1'b0);
            end else if (r < 84) begin
                // Truncated: a lead followed by too few continuations.
                send_request(8'($urandom_range(8'hE0, 8'hF4)), 1'b0);
                repeat ($urandom_range(0, 1)) send_request(cont_byte(), 1'b0);
                send_request(8'($urandom_range(0, 127)), 1'b0);
            end else if (r < 90) begin
                send_request(8'($urandom_range(8'hC2, 8'hF4)), 1'b0);
                if ($urandom_range(0, 1))
                    send_request(8'($urandom_range(8'h00, 8'h7F)), 1'b0);
                else
                    send_request(8'($urandom_range(8'hC0, 8'hFF)), 1'b0);
            end else if (r < 94) begin
                send_request(cont_byte(), 1'b0);
            end else if (r < 97) begin
                if ($urandom_range(0, 1))
                    send_request(8'($urandom_range(8'hC0, 8'hC1)), 1'b0);
                else
                    send_request(8'($urandom_range(8'hF5, 8'hFF)), 1'b0);
            end else begin
                send_end();
            end
        end
        wait_idle();
    endtask

    // ---------------------------------------------------------------- sequence

    initial begin
        i_rst_n             <= 1'b0;
        in_ch.valid         <= 1'b0;
        in_ch.data_byte     <= '0;
        in_ch.end_of_stream <= 1'b0;
        psel                <= 1'b0;
        penable             <= 1'b0;
        pwrite              <= 1'b0;
        paddr               <= '0;
        pwdata              <= '0;
        cfg_utf8   = 1'b0;
        bom_phase  = PhNone;
        bom_seen   = 1'b0;
        cont_left  = '0;
        acc_value  = '0;
        run_count  = 0;
        fail_count = 0;
        items_sent = 0;
        src_quiet  = 1'b0;
        sink_quiet = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_stream_opening();
        test_raw_bytes();
        test_utf8_sequences();
        test_mode_switch_mid_sequence();
        test_random_stream(1'b1, 110);
        test_random_stream(1'b0, 70);
        test_random_stream(1'b1, 110);
        test_random_stream(1'b0, 40);
        test_random_stream(1'b1, 50);

        while (pending_points.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && pending_points.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
sv/u8d_pkg.sv
sv/u8d_in_if.sv
sv/u8d_out_if.sv
sv/u8d_cfg.sv
sv/u8d_core.sv
sv/u8d_out_buf.sv
sv/utf8_stream_decoder.sv
sv/u8d_checker.sv
bench/tb_utf8_stream_decoder.sv
